/* rtl/tpef_pkg.sv */
package tpef_pkg;

  // Request operation codes.
  typedef enum logic [1:0] {
    OP_SEND  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_HIGH_SIZE = 2'd0,
    CFG_LOW_SIZE  = 2'd1,
    CFG_QUEUE_NUM = 2'd2
  } cfg_idx_e;

  // Sequencer states, one-hot.
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_e;

  localparam int unsigned OpW      = 2;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned SizeW    = 3;
  localparam int unsigned NodeW    = 16;
  localparam int unsigned TypeW    = 8;
  localparam int unsigned EvIdW    = 16;
  localparam int unsigned QnumW    = 16;
  localparam int unsigned WordW    = 64;
  localparam int unsigned RingCntW = 4;
  localparam int unsigned TotCntW  = 5;
  localparam logic [SizeW-1:0] SizeReset = 3'd4;
  // Largest size code the register can express.
  localparam int unsigned SizeCodeMax = 7;

  // One stored event: the tag fields and the payload word.
  typedef struct packed {
    logic [QnumW-1:0] qid;
    logic [EvIdW-1:0] ev_serial;
    logic             owned_buf;
    logic [TypeW-1:0] ev_kind;
    logic [NodeW-1:0] node_id;
    logic [WordW-1:0] payload;
  } entry_t;

  // Floor of log2, at least 1, used to size the ring pointers.
  function automatic int unsigned ring_ptr_bits(int unsigned depth);
    int unsigned k;
    k = 0;
    while (k < 16 && (2 << k) <= depth) begin
      k++;
    end
    if (k < 1) begin
      k = 1;
    end
    return k;
  endfunction

endpackage

/* rtl/two_priority_event_fifo_top.sv */
// Event queue with a high-priority and a low-priority ring FIFO, each held in a
// single-port-write, registered-read memory of HIGH_DEPTH or LOW_DEPTH entries.
// A send, a clear, a refused pop or an unknown op has its result registered as it
// is accepted; a pop that returns an event first passes through the read state,
// because the ring memory read is registered and the sequencer waits for its
// data. A new request is taken when the sequencer is idle and the result
// register is empty or being emptied in that cycle. The size registers select 2
// to 2^7 ring slots (never more than the depth), one slot stays unused, and
// writing a size register empties that ring. Memory contents are not cleared at
// reset; ring pointers guarantee that only written entries are ever read.
module two_priority_event_fifo_top #(
  parameter int unsigned HIGH_DEPTH = 16,
  parameter int unsigned LOW_DEPTH  = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write port.
  input  logic                            cfg_we_i,
  input  logic [tpef_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [tpef_pkg::CfgDataW-1:0]   cfg_data_i,
  // Request channel.
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [tpef_pkg::OpW-1:0]        op_i,
  input  logic                            is_high_i,
  input  logic [tpef_pkg::NodeW-1:0]      node_id_i,
  input  logic [tpef_pkg::TypeW-1:0]      ev_kind_i,
  input  logic                            owned_buf_i,
  input  logic [tpef_pkg::EvIdW-1:0]      ev_serial_i,
  input  logic [tpef_pkg::WordW-1:0]      payload_i,
  // Result channel.
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            ok_o,
  output logic [tpef_pkg::NodeW-1:0]      out_node_id_o,
  output logic [tpef_pkg::TypeW-1:0]      out_ev_kind_o,
  output logic                            out_malloc_o,
  output logic [tpef_pkg::EvIdW-1:0]      out_ev_serial_o,
  output logic [tpef_pkg::QnumW-1:0]      out_qid_o,
  output logic [tpef_pkg::WordW-1:0]      out_payload_o,
  output logic [tpef_pkg::RingCntW-1:0]   high_count_o,
  output logic [tpef_pkg::RingCntW-1:0]   low_count_o,
  output logic [tpef_pkg::TotCntW-1:0]    total_count_o
);

  import tpef_pkg::*;

  localparam int unsigned HPtrW   = ring_ptr_bits(HIGH_DEPTH);
  localparam int unsigned LPtrW   = ring_ptr_bits(LOW_DEPTH);
  localparam int unsigned HAddrW  = $clog2(HIGH_DEPTH);
  localparam int unsigned LAddrW  = $clog2(LOW_DEPTH);
  localparam int unsigned HLgMax  = (HPtrW < SizeCodeMax) ? HPtrW : SizeCodeMax;
  localparam int unsigned LLgMax  = (LPtrW < SizeCodeMax) ? LPtrW : SizeCodeMax;
  localparam int unsigned SumW    = ((HPtrW > LPtrW) ? HPtrW : LPtrW) + 1;
  localparam int unsigned EntryW  = $bits(entry_t);

  // Configuration registers.
  logic [SizeW-1:0] high_size_q, low_size_q;
  logic [QnumW-1:0] queue_num_q;

  // Ring pointers.
  logic [HPtrW-1:0] high_head_q, high_head_d, high_tail_q, high_tail_d;
  logic [LPtrW-1:0] low_head_q, low_head_d, low_tail_q, low_tail_d;

  // Sequencer and result register.
  state_e               state_q, state_d;
  logic                 sel_high_q;
  logic                 out_valid_q;
  logic                 ok_q;
  entry_t               out_entry_q;
  logic [RingCntW-1:0]  high_cnt_q, low_cnt_q;
  logic [TotCntW-1:0]   tot_cnt_q;

  // Datapath signals.
  logic [SizeW-1:0] high_lg, low_lg;
  logic [HPtrW-1:0] high_mask, high_inc, high_cnt;
  logic [LPtrW-1:0] low_mask, low_inc, low_cnt;
  logic [SumW-1:0]  tot_cnt;
  logic             in_fire, send_ok, pop_high, pop_low, pop_hit, ok_d;
  logic             high_we, low_we, high_re, low_re;
  op_e              op;
  entry_t           wr_entry, rd_entry;
  logic [EntryW-1:0] high_rdata, low_rdata;

  // Clamp the size codes to the usable range and expand them to ring masks.
  always_comb begin
    high_lg = high_size_q;
    if (high_size_q < 1) begin
      high_lg = SizeW'(1);
    end else if (high_size_q > HLgMax) begin
      high_lg = SizeW'(HLgMax);
    end
    low_lg = low_size_q;
    if (low_size_q < 1) begin
      low_lg = SizeW'(1);
    end else if (low_size_q > LLgMax) begin
      low_lg = SizeW'(LLgMax);
    end
    for (int i = 0; i < HPtrW; i++) begin
      high_mask[i] = (i < high_lg);
    end
    for (int i = 0; i < LPtrW; i++) begin
      low_mask[i] = (i < low_lg);
    end
  end

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;
  assign op         = op_e'(op_i);

  // Write side: the head slot of the chosen ring.
  assign high_inc = (high_head_q + 1'b1) & high_mask;
  assign low_inc  = (low_head_q + 1'b1) & low_mask;
  assign send_ok  = is_high_i ? (high_inc != high_tail_q) : (low_inc != low_tail_q);
  assign pop_high = (high_head_q != high_tail_q);
  assign pop_low  = !pop_high && (low_head_q != low_tail_q);
  assign pop_hit  = pop_high || pop_low;

  always_comb begin
    wr_entry           = '0;
    wr_entry.qid       = queue_num_q;
    wr_entry.ev_serial = ev_serial_i;
    wr_entry.owned_buf = owned_buf_i;
    wr_entry.ev_kind   = ev_kind_i;
    wr_entry.node_id   = node_id_i;
    wr_entry.payload   = payload_i;
  end

  // Pointer updates and the result flag for the accepted request.
  always_comb begin
    high_head_d = high_head_q;
    high_tail_d = high_tail_q;
    low_head_d  = low_head_q;
    low_tail_d  = low_tail_q;
    ok_d        = 1'b0;
    high_we     = 1'b0;
    low_we      = 1'b0;
    high_re     = 1'b0;
    low_re      = 1'b0;
    if (in_fire) begin
      case (op)
        OP_SEND: begin
          if (send_ok) begin
            ok_d = 1'b1;
            if (is_high_i) begin
              high_we     = 1'b1;
              high_head_d = high_inc;
            end else begin
              low_we     = 1'b1;
              low_head_d = low_inc;
            end
          end
        end
        OP_POP: begin
          ok_d = pop_hit;
          if (pop_high) begin
            high_re     = 1'b1;
            high_tail_d = (high_tail_q + 1'b1) & high_mask;
          end else if (pop_low) begin
            low_re     = 1'b1;
            low_tail_d = (low_tail_q + 1'b1) & low_mask;
          end
        end
        OP_CLEAR: begin
          high_head_d = '0;
          high_tail_d = '0;
          low_head_d  = '0;
          low_tail_d  = '0;
        end
        default: begin
          ok_d = 1'b0;
        end
      endcase
    end
    // A size write empties that ring.
    if (cfg_we_i && cfg_idx_e'(cfg_index_i) == CFG_HIGH_SIZE) begin
      high_head_d = '0;
      high_tail_d = '0;
    end
    if (cfg_we_i && cfg_idx_e'(cfg_index_i) == CFG_LOW_SIZE) begin
      low_head_d = '0;
      low_tail_d = '0;
    end
  end

  // Ring occupancy after the request.
  assign high_cnt = (high_head_d - high_tail_d) & high_mask;
  assign low_cnt  = (low_head_d - low_tail_d) & low_mask;
  assign tot_cnt  = SumW'(high_cnt) + SumW'(low_cnt);

  // Sequencer: a successful pop waits in the read state for the memory data.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (high_re || low_re) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign rd_entry = sel_high_q ? entry_t'(high_rdata) : entry_t'(low_rdata);

  // Control state, configuration and ring pointers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      sel_high_q  <= 1'b0;
      high_size_q <= SizeReset;
      low_size_q  <= SizeReset;
      queue_num_q <= '0;
      high_head_q <= '0;
      high_tail_q <= '0;
      low_head_q  <= '0;
      low_tail_q  <= '0;
    end else begin
      state_q     <= state_d;
      high_head_q <= high_head_d;
      high_tail_q <= high_tail_d;
      low_head_q  <= low_head_d;
      low_tail_q  <= low_tail_d;
      if (high_re || low_re) begin
        sel_high_q <= high_re;
      end
      // The result is visible once its event data is in place.
      if (in_fire) begin
        out_valid_q <= !(high_re || low_re);
      end else if (state_q == ST_READ) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      // Register writes; the ring pointers are emptied in the pointer logic.
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_HIGH_SIZE: begin
            high_size_q <= cfg_data_i[SizeW-1:0];
          end
          CFG_LOW_SIZE: begin
            low_size_q <= cfg_data_i[SizeW-1:0];
          end
          CFG_QUEUE_NUM: begin
            queue_num_q <= cfg_data_i[QnumW-1:0];
          end
          default: begin
            queue_num_q <= queue_num_q;
          end
        endcase
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ok_q        <= ok_d;
      out_entry_q <= '0;
      high_cnt_q  <= (high_cnt > 15) ? RingCntW'(15) : RingCntW'(high_cnt);
      low_cnt_q   <= (low_cnt > 15) ? RingCntW'(15) : RingCntW'(low_cnt);
      tot_cnt_q   <= (tot_cnt > 31) ? TotCntW'(31) : TotCntW'(tot_cnt);
    end else if (state_q == ST_READ) begin
      out_entry_q <= rd_entry;
    end
  end

  // Ring memories. Writes and reads come from different requests, so a read
  // always sees an earlier write to the same slot.
  tpef_ram #(
    .Width (EntryW),
    .Depth (HIGH_DEPTH)
  ) u_high_ram (
    .clk_i   (clk_i),
    .we_i    (high_we),
    .waddr_i (HAddrW'(high_head_q)),
    .wdata_i (wr_entry),
    .re_i    (high_re),
    .raddr_i (HAddrW'(high_tail_q)),
    .rdata_o (high_rdata)
  );

  tpef_ram #(
    .Width (EntryW),
    .Depth (LOW_DEPTH)
  ) u_low_ram (
    .clk_i   (clk_i),
    .we_i    (low_we),
    .waddr_i (LAddrW'(low_head_q)),
    .wdata_i (wr_entry),
    .re_i    (low_re),
    .raddr_i (LAddrW'(low_tail_q)),
    .rdata_o (low_rdata)
  );

  assign out_valid_o     = out_valid_q;
  assign ok_o            = ok_q;
  assign out_node_id_o   = out_entry_q.node_id;
  assign out_ev_kind_o   = out_entry_q.ev_kind;
  assign out_malloc_o    = out_entry_q.owned_buf;
  assign out_ev_serial_o = out_entry_q.ev_serial;
  assign out_qid_o       = out_entry_q.qid;
  assign out_payload_o   = out_entry_q.payload;
  assign high_count_o    = high_cnt_q;
  assign low_count_o     = low_cnt_q;
  assign total_count_o   = tot_cnt_q;

  // The result register is empty while the memory data is on its way.
  a_read_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> !out_valid_q)
    else $error("result register busy during memory read");

  // A pop that finds an event is followed by the memory read state.
  a_pop_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && op == OP_POP && pop_hit) |=> (state_q == ST_READ && !in_ready_o))
    else $error("pop did not wait for memory data");

  // A ring memory is never written and read in the same cycle.
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((high_we || low_we) && (high_re || low_re)))
    else $error("ring memory written and read together");

endmodule

/* rtl/tpef_ram.sv */
module tpef_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Single write port, registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* dv/testbench.sv */
module testbench;
  import tpef_pkg::*;

  // Both rings are built with the default depth of 16 entries.
  localparam int unsigned RingLog2   = 4;
  localparam logic [OpW-1:0] OpReserved = 2'd3;
  localparam int unsigned NumPhases  = 12;
  localparam int unsigned PhaseItems = 145;
  localparam int unsigned HoldCycles = 300;

  // One request as the sender presents it.
  typedef struct {
    logic [OpW-1:0]   op;
    logic             is_high;
    logic [NodeW-1:0] node_id;
    logic [TypeW-1:0] ev_kind;
    logic             owned_buf;
    logic [EvIdW-1:0] ev_serial;
    logic [WordW-1:0] payload;
  } request_t;

  // One result as the block should return it.
  typedef struct packed {
    logic                ok;
    entry_t              ev;
    logic [RingCntW-1:0] high_cnt;
    logic [RingCntW-1:0] low_cnt;
    logic [TotCntW-1:0]  total_cnt;
  } result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [OpW-1:0]      op_i;
  logic                is_high_i;
  logic [NodeW-1:0]    node_id_i;
  logic [TypeW-1:0]    ev_kind_i;
  logic                owned_buf_i;
  logic [EvIdW-1:0]    ev_serial_i;
  logic [WordW-1:0]    payload_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic                ok_o;
  logic [NodeW-1:0]    out_node_id_o;
  logic [TypeW-1:0]    out_ev_kind_o;
  logic                out_malloc_o;
  logic [EvIdW-1:0]    out_ev_serial_o;
  logic [QnumW-1:0]    out_qid_o;
  logic [WordW-1:0]    out_payload_o;
  logic [RingCntW-1:0] high_count_o;
  logic [RingCntW-1:0] low_count_o;
  logic [TotCntW-1:0]  total_count_o;

  // Shared run state.
  result_t expected_results[$];
  int      errors      = 0;
  int      n_requests  = 0;
  int      n_results   = 0;
  int      n_popped    = 0;
  int      n_refused   = 0;
  int      n_cfg       = 0;
  bit      idle_on     = 1'b1;
  bit      hold_req    = 1'b0;

  // Shadow copy of the queue state.
  logic [RingCntW-1:0] hi_head, hi_tail, lo_head, lo_tail;
  entry_t              hi_ring [16];
  entry_t              lo_ring [16];
  logic [SizeW-1:0]    hi_size, lo_size;
  logic [QnumW-1:0]    qnum;

  two_priority_event_fifo_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .is_high_i       (is_high_i),
    .node_id_i       (node_id_i),
    .ev_kind_i       (ev_kind_i),
    .owned_buf_i     (owned_buf_i),
    .ev_serial_i     (ev_serial_i),
    .payload_i       (payload_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .ok_o            (ok_o),
    .out_node_id_o   (out_node_id_o),
    .out_ev_kind_o   (out_ev_kind_o),
    .out_malloc_o    (out_malloc_o),
    .out_ev_serial_o (out_ev_serial_o),
    .out_qid_o       (out_qid_o),
    .out_payload_o   (out_payload_o),
    .high_count_o    (high_count_o),
    .low_count_o     (low_count_o),
    .total_count_o   (total_count_o)
  );

  // Free-running clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Slot mask of a ring for a size code, clamped to the built depth.
  function automatic logic [RingCntW-1:0] size_mask(input logic [SizeW-1:0] code);
    int unsigned lg;
    lg = 32'(code);
    if (lg < 1) lg = 1;
    if (lg > RingLog2) lg = RingLog2;
    return RingCntW'((1 << lg) - 1);
  endfunction

  // Apply one accepted request to the shadow state and return its result.
  function automatic result_t apply_request(input request_t r);
    result_t             res;
    entry_t              ev;
    logic [RingCntW-1:0] hm, lm;
    hm  = size_mask(hi_size);
    lm  = size_mask(lo_size);
    res = '0;
    ev.qid       = qnum;
    ev.ev_serial = r.ev_serial;
    ev.owned_buf = r.owned_buf;
    ev.ev_kind   = r.ev_kind;
    ev.node_id   = r.node_id;
    ev.payload   = r.payload;
    case (r.op)
      OP_SEND: begin
        if (r.is_high) begin
          if (((hi_head + 4'd1) & hm) != hi_tail) begin
            hi_ring[hi_head & hm] = ev;
            hi_head = (hi_head + 4'd1) & hm;
            res.ok = 1'b1;
          end
        end else begin
          if (((lo_head + 4'd1) & lm) != lo_tail) begin
            lo_ring[lo_head & lm] = ev;
            lo_head = (lo_head + 4'd1) & lm;
            res.ok = 1'b1;
          end
        end
        if (!res.ok) n_refused++;
      end
      OP_POP: begin
        // High priority events always leave first.
        if (hi_head != hi_tail) begin
          res.ev  = hi_ring[hi_tail & hm];
          hi_tail = (hi_tail + 4'd1) & hm;
          res.ok  = 1'b1;
        end else if (lo_head != lo_tail) begin
          res.ev  = lo_ring[lo_tail & lm];
          lo_tail = (lo_tail + 4'd1) & lm;
          res.ok  = 1'b1;
        end
        if (res.ok) n_popped++;
      end
      OP_CLEAR: begin
        hi_head = '0;
        hi_tail = '0;
        lo_head = '0;
        lo_tail = '0;
      end
      default: ;
    endcase
    res.high_cnt  = (hi_head - hi_tail) & hm;
    res.low_cnt   = (lo_head - lo_tail) & lm;
    res.total_cnt = {1'b0, res.high_cnt} + {1'b0, res.low_cnt};
    return res;
  endfunction

  // Random request with the given share of sends in percent.
  function automatic request_t random_request(input int send_pct);
    request_t r;
    int       roll;
    roll = $urandom_range(0, 99);
    if (roll < send_pct) r.op = OP_SEND;
    else if (roll < 94) r.op = OP_POP;
    else if (roll < 98) r.op = OP_CLEAR;
    else r.op = OpReserved;
    r.is_high   = 1'($urandom_range(0, 1));
    r.node_id   = NodeW'($urandom);
    r.ev_kind   = TypeW'($urandom);
    r.owned_buf = 1'($urandom_range(0, 1));
    r.ev_serial = EvIdW'($urandom);
    r.payload   = {$urandom, $urandom};
    return r;
  endfunction

  function automatic request_t send_with(input logic hi, input logic all_ones);
    request_t r;
    r.op        = OP_SEND;
    r.is_high   = hi;
    r.node_id   = {NodeW{all_ones}};
    r.ev_kind   = {TypeW{all_ones}};
    r.owned_buf = all_ones;
    r.ev_serial = {EvIdW{all_ones}};
    r.payload   = {WordW{all_ones}};
    return r;
  endfunction

  function automatic request_t plain_op(input logic [OpW-1:0] op);
    request_t r;
    r    = random_request(0);
    r.op = op;
    return r;
  endfunction

  function automatic void check_field(input string label, input logic [63:0] want_v,
                                      input logic [63:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t ERROR %s: expected %0h, got %0h", $time, label, want_v, got_v);
      errors++;
    end
  endfunction

  // Offer one request and hold it until the block takes it. Called just after
  // a rising edge; returns just after the edge that accepted the request.
  task automatic send_request(input request_t r);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    op_i        <= r.op;
    is_high_i   <= r.is_high;
    node_id_i   <= r.node_id;
    ev_kind_i   <= r.ev_kind;
    owned_buf_i <= r.owned_buf;
    ev_serial_i <= r.ev_serial;
    payload_i   <= r.payload;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    expected_results.push_back(apply_request(r));
    n_requests++;
    @(posedge clk_i);
  endtask

  // Stop sending and wait until every outstanding result has come back.
  task automatic wait_idle();
    int guard;
    in_valid_i <= 1'b0;
    guard = 0;
    while (expected_results.size() != 0 && guard < 20000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (4) @(posedge clk_i);
  endtask

  // Write one configuration register; only called while the block is idle.
  task automatic write_register(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_HIGH_SIZE: begin
        hi_size = data[SizeW-1:0];
        hi_head = '0;
        hi_tail = '0;
      end
      CFG_LOW_SIZE: begin
        lo_size = data[SizeW-1:0];
        lo_head = '0;
        lo_tail = '0;
      end
      CFG_QUEUE_NUM: qnum = data;
      default: ;
    endcase
    n_cfg++;
  endtask

  // Priority order, field extremes and the pop of an empty queue.
  task automatic test_priority_order();
    send_request(plain_op(OP_POP));
    send_request(send_with(1'b1, 1'b1));
    send_request(send_with(1'b0, 1'b0));
    send_request(send_with(1'b1, 1'b0));
    send_request(send_with(1'b0, 1'b1));
    repeat (5) send_request(plain_op(OP_POP));
  endtask

  // A clear empties both rings; the reserved op changes nothing.
  task automatic test_clear_and_unknown();
    request_t r;
    r    = send_with(1'b1, 1'b1);
    r.op = OpReserved;
    send_request(r);
    send_request(send_with(1'b1, 1'b1));
    send_request(send_with(1'b0, 1'b1));
    send_request(plain_op(OpReserved));
    send_request(plain_op(OP_CLEAR));
    send_request(plain_op(OP_POP));
  endtask

  // Out-of-range size codes clamp, and a size write empties that ring.
  task automatic test_size_registers();
    request_t r;
    wait_idle();
    write_register(CFG_HIGH_SIZE, 16'd0);
    write_register(CFG_LOW_SIZE, 16'd7);
    write_register(CFG_QUEUE_NUM, 16'hFFFF);
    r = random_request(100); r.is_high = 1'b1; send_request(r);
    r = random_request(100); r.is_high = 1'b1; send_request(r);
    r = random_request(100); r.is_high = 1'b0; send_request(r);
    repeat (3) send_request(plain_op(OP_POP));
    r = random_request(100); r.is_high = 1'b1; send_request(r);
    r = random_request(100); r.is_high = 1'b0; send_request(r);
    wait_idle();
    write_register(CFG_HIGH_SIZE, 16'd1);
    repeat (2) send_request(plain_op(OP_POP));
    r = random_request(100); r.is_high = 1'b1; send_request(r);
    r = random_request(100); r.is_high = 1'b0; send_request(r);
    wait_idle();
    write_register(CFG_LOW_SIZE, 16'd4);
    repeat (2) send_request(plain_op(OP_POP));
  endtask

  // The receiver holds off for a long stretch while requests keep coming,
  // so the result register fills and the block stops taking requests.
  task automatic test_backpressure();
    wait_idle();
    idle_on = 1'b0;
    @(negedge clk_i);
    hold_req = 1'b1;
    @(posedge clk_i);
    repeat (60) send_request(random_request(80));
    wait_idle();
    idle_on = 1'b1;
  endtask

  // Random traffic over a series of register settings.
  task automatic test_random_phases();
    logic [SizeW-1:0]    hi_code, lo_code;
    logic [CfgDataW-1:0] hi_data, lo_data, qn;
    int                  send_pct;
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: begin hi_code = 3'd4; lo_code = 3'd4; end
        1: begin hi_code = 3'd1; lo_code = 3'd1; end
        2: begin hi_code = 3'd0; lo_code = 3'd7; end
        3: begin hi_code = 3'd7; lo_code = 3'd0; end
        default: begin
          hi_code = SizeW'($urandom_range(0, SizeCodeMax));
          lo_code = SizeW'($urandom_range(0, SizeCodeMax));
        end
      endcase
      hi_data = {13'($urandom), hi_code};
      lo_data = {13'($urandom), lo_code};
      if (p == 0) qn = '0;
      else if (p == 1) qn = 16'hFFFF;
      else qn = CfgDataW'($urandom);
      case (p % 3)
        0: send_pct = 70;
        1: send_pct = 30;
        default: send_pct = 50;
      endcase
      wait_idle();
      // Some phases keep the stored events and change only the stamp.
      if (p < 4 || p % 3 != 0) begin
        write_register(CFG_HIGH_SIZE, hi_data);
        write_register(CFG_LOW_SIZE, lo_data);
      end
      write_register(CFG_QUEUE_NUM, qn);
      idle_on = (p < NumPhases - 3) && (p != 5);
      repeat (PhaseItems) send_request(random_request(send_pct));
    end
  endtask

  // Receiver pacing: random stall bursts plus the requested long hold.
  initial begin : result_pacing
    int stall_left;
    int hold_left;
    stall_left  = 0;
    hold_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left  = $urandom_range(0, 10);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(negedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t ERROR unexpected result: expected none, got ok=%0b", $time, ok_o);
        errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("ok", 64'(want.ok), 64'(ok_o));
        check_field("out_node_id", 64'(want.ev.node_id), 64'(out_node_id_o));
        check_field("out_ev_kind", 64'(want.ev.ev_kind), 64'(out_ev_kind_o));
        check_field("out_malloc", 64'(want.ev.owned_buf), 64'(out_malloc_o));
        check_field("out_ev_serial", 64'(want.ev.ev_serial), 64'(out_ev_serial_o));
        check_field("out_qid", 64'(want.ev.qid), 64'(out_qid_o));
        check_field("out_payload", want.ev.payload, out_payload_o);
        check_field("high_count", 64'(want.high_cnt), 64'(high_count_o));
        check_field("low_count", 64'(want.low_cnt), 64'(low_count_o));
        check_field("total_count", 64'(want.total_cnt), 64'(total_count_o));
        n_results++;
      end
    end
  end

  // Main sequence.
  initial begin : run_tests
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    op_i          = '0;
    is_high_i     = 1'b0;
    node_id_i     = '0;
    ev_kind_i     = '0;
    owned_buf_i   = 1'b0;
    ev_serial_i   = '0;
    payload_i     = '0;
    hi_head       = '0;
    hi_tail       = '0;
    lo_head       = '0;
    lo_tail       = '0;
    hi_size       = SizeReset;
    lo_size       = SizeReset;
    qnum          = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_priority_order();
    test_clear_and_unknown();
    test_size_registers();
    test_backpressure();
    test_random_phases();
    wait_idle();
    repeat (8) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $display("%0t ERROR expected %0d more results, got none", $time,
               expected_results.size());
      errors++;
    end
    $display("Summary: %0d requests, %0d results checked, %0d events popped, %0d sends refused.",
             n_requests, n_results, n_popped, n_refused);
    $display("Summary: %0d register writes over clamped, minimum and maximum ring sizes.",
             n_cfg);
    if (errors == 0) begin
      $display("PASS two_priority_event_fifo_top");
    end else begin
      $display("FAIL two_priority_event_fifo_top");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin : watchdog
    #4000000;
    $display("FAIL two_priority_event_fifo_top");
    $finish;
  end

endmodule

/* files.f */
rtl/tpef_pkg.sv
rtl/tpef_ram.sv
rtl/two_priority_event_fifo_top.sv
dv/testbench.sv
